@@ sv/esd_pkg.sv @@
package esd_pkg;

    // Decoder phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;
    localparam logic [1:0] PH_OCT  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Characters with a special role
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_U         = 8'h75;

    // Largest value that fits in narrow mode
    localparam logic [15:0] NARROW_MAX = 16'h00FF;

    // digits_left loads: hex is 4 plus digits allowed after the first, octal the digits left
    localparam logic [2:0] DL_HEX_X  = 3'd5;
    localparam logic [2:0] DL_HEX_U  = 3'd7;
    localparam logic [2:0] DL_OCT    = 3'd2;
    localparam logic [2:0] DL_NODIG  = 3'd4;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
        logic        end_of_text;
        logic        last;
    } result_t;

    // Return {hit, digit} for a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            r = {1'b1, ch[3:0]};
        end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Return {hit, code} for the eleven simple escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] ch);
        logic [8:0] r;
        case (ch)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h74:   r = {1'b1, 8'd9};
            8'h6E:   r = {1'b1, 8'd10};
            8'h76:   r = {1'b1, 8'd11};
            8'h66:   r = {1'b1, 8'd12};
            8'h72:   r = {1'b1, 8'd13};
            8'h3F:   r = {1'b1, 8'd63};
            8'h5C:   r = {1'b1, 8'd92};
            8'h27:   r = {1'b1, 8'd39};
            8'h22:   r = {1'b1, 8'd34};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/escape_sequence_decoder.sv @@
// Escape-sequence decoder: takes one source byte of a literal per beat and
// returns the decoded characters, handling simple escapes, \x (one or two hex
// digits), \u (one to four hex digits) and octal escapes (up to three digits).
// Each input beat yields zero, one or two result beats; m_last marks the final
// one. An input beat is taken every cycle while the two-entry result register
// is empty, or holds one result that leaves in the same cycle, so the block
// runs at one byte per cycle whenever each byte gives at most one result and
// m_ready stays high; a byte that gives two results holds the input while the
// second result drains. The first result appears in the cycle after the beat.
// The narrow_mode bit (cfg_wr_en/cfg_wr_data) flags values above 255 with
// status 2; write it only while the block is idle.
module escape_sequence_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_flush,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_value,
    output logic [1:0]  m_status,
    output logic        m_end_of_text,
    output logic        m_last
);
    import esd_pkg::*;

    logic        narrow_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  dl_reg, dl_next;

    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  cnt_reg, cnt_next;

    result_t     r0, r1;
    logic [1:0]  n_res;

    logic        in_fire, out_fire;
    logic [4:0]  hex_hit;
    logic [8:0]  esc_hit;
    logic        is_digit;
    logic [15:0] acc_dig;
    logic [2:0]  dl_dig;

    assign out_fire = m_valid && m_ready;
    assign s_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign in_fire  = s_valid && s_ready;

    function automatic result_t mk(input logic [15:0] v, input logic [1:0] st,
                                   input logic eot);
        result_t r;
        r.value       = v;
        r.status      = st;
        r.end_of_text = eot;
        r.last        = 1'b0;
        return r;
    endfunction

    // Status of a decoded value under the current mode
    function automatic logic [1:0] range_status(input logic nm, input logic [15:0] v);
        return (nm && (v > NARROW_MAX)) ? ST_RANGE : ST_OK;
    endfunction

    // Digit decode and accumulate for the numeric phases
    always_comb begin
        hex_hit = hex_digit(s_char_code);
        esc_hit = simple_escape(s_char_code);
        if (phase_reg == PH_HEX) begin
            is_digit = hex_hit[4];
            acc_dig  = {acc_reg[11:0], hex_hit[3:0]};
        end else begin
            is_digit = s_char_code inside {[8'h30:8'h37]};
            acc_dig  = {acc_reg[12:0], s_char_code[2:0]};
        end
        if (dl_reg >= DL_NODIG) begin
            dl_dig = dl_reg - DL_NODIG;
        end else if (dl_reg != 3'd0) begin
            dl_dig = dl_reg - 3'd1;
        end else begin
            dl_dig = 3'd0;
        end
    end

    // Decode one input beat into up to two results and the next state
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dl_next    = dl_reg;
        r0         = mk(16'd0, ST_OK, 1'b0);
        r1         = mk(16'd0, ST_OK, 1'b0);
        n_res      = 2'd0;

        if (s_flush) begin
            if ((phase_reg == PH_ESC) || ((phase_reg == PH_HEX) && (dl_reg >= DL_NODIG))) begin
                r0    = mk(16'd0, ST_INVALID, 1'b0);
                r1    = mk(16'd0, ST_OK, 1'b1);
                n_res = 2'd2;
            end else if ((phase_reg == PH_HEX) || (phase_reg == PH_OCT)) begin
                r0    = mk(acc_reg, range_status(narrow_reg, acc_reg), 1'b0);
                r1    = mk(16'd0, ST_OK, 1'b1);
                n_res = 2'd2;
            end else begin
                r0    = mk(16'd0, ST_OK, 1'b1);
                n_res = 2'd1;
            end
            phase_next = PH_IDLE;
            acc_next   = 16'd0;
            dl_next    = 3'd0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_char_code == CH_BACKSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        r0    = mk({8'h00, s_char_code}, ST_OK, 1'b0);
                        n_res = 2'd1;
                    end
                end
                PH_ESC: begin
                    phase_next = PH_IDLE;
                    acc_next   = 16'd0;
                    dl_next    = 3'd0;
                    if (esc_hit[8]) begin
                        r0    = mk({8'h00, esc_hit[7:0]}, ST_OK, 1'b0);
                        n_res = 2'd1;
                    end else if (s_char_code == CH_X) begin
                        phase_next = PH_HEX;
                        dl_next    = DL_HEX_X;
                    end else if (s_char_code == CH_U) begin
                        phase_next = PH_HEX;
                        dl_next    = DL_HEX_U;
                    end else if (s_char_code inside {[8'h30:8'h37]}) begin
                        phase_next = PH_OCT;
                        acc_next   = {13'd0, s_char_code[2:0]};
                        dl_next    = DL_OCT;
                    end else begin
                        r0    = mk(16'd0, ST_INVALID, 1'b0);
                        n_res = 2'd1;
                    end
                end
                default: begin
                    if (is_digit) begin
                        if (dl_dig == 3'd0) begin
                            r0         = mk(acc_dig, range_status(narrow_reg, acc_dig), 1'b0);
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                            acc_next   = 16'd0;
                            dl_next    = 3'd0;
                        end else begin
                            acc_next = acc_dig;
                            dl_next  = dl_dig;
                        end
                    end else if ((phase_reg == PH_HEX) && (dl_reg >= DL_NODIG)) begin
                        r0         = mk(16'd0, ST_INVALID, 1'b0);
                        n_res      = 2'd1;
                        phase_next = PH_IDLE;
                        acc_next   = 16'd0;
                        dl_next    = 3'd0;
                    end else begin
                        // Emit the value so far, then treat the byte as in idle
                        r0       = mk(acc_reg, range_status(narrow_reg, acc_reg), 1'b0);
                        acc_next = 16'd0;
                        dl_next  = 3'd0;
                        if (s_char_code == CH_BACKSLASH) begin
                            phase_next = PH_ESC;
                            n_res      = 2'd1;
                        end else begin
                            phase_next = PH_IDLE;
                            r1         = mk({8'h00, s_char_code}, ST_OK, 1'b0);
                            n_res      = 2'd2;
                        end
                    end
                end
            endcase
        end

        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    // Load a new result pair, or advance the pair as results leave
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (in_fire) begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = n_res;
        end else if (out_fire) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            narrow_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
            acc_reg    <= 16'd0;
            dl_reg     <= 3'd0;
            cnt_reg    <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                narrow_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                dl_reg    <= dl_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_value       = slot0_reg.value;
    assign m_status      = slot0_reg.status;
    assign m_end_of_text = slot0_reg.end_of_text;
    assign m_last        = slot0_reg.last;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    a_flush_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_flush) |=> (phase_reg == PH_IDLE && acc_reg == 16'd0 && dl_reg == 3'd0))
        else $error("state not cleared after flush");

    a_eot_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_text) |-> m_last)
        else $error("end-of-text result is not the last one");

    a_oct_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OCT) |-> (dl_reg <= DL_OCT && dl_reg != 3'd0))
        else $error("octal digit count out of range");
`endif

endmodule
